// ===== hw/rtl/kmdb_pkg.sv =====
// ============================================================================
// kmdb_pkg
// types and constants shared by the knight move distance search block
// ============================================================================
`default_nettype none

package kmdb_pkg;

    localparam int COORD_IN_W = 8;
    localparam int SIDE_W     = 9;
    localparam int DIST_W     = 8;
    localparam int MOVES      = 8;
    localparam int MOVE_W     = 3;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd8;

    // knight steps in (row, col)
    localparam logic signed [2:0] KNIGHT_ROW [MOVES] = '{
        3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1
    };
    localparam logic signed [2:0] KNIGHT_COL [MOVES] = '{
        3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1, 3'sd1, 3'sd2
    };

    typedef struct packed {
        logic [COORD_IN_W-1:0] start_row;
        logic [COORD_IN_W-1:0] start_col;
        logic [COORD_IN_W-1:0] target_row;
        logic [COORD_IN_W-1:0] target_col;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] move_count;
        logic              reachable;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clr_start;
        logic clear;
        logic seed;
        logic fetch;
        logic load;
        logic issue;
        logic test;
        logic res_zero;
        logic res_reach;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic off_board;
        logic same_square;
        logic clear_last;
        logic fifo_empty;
        logic move_last;
        logic hit;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/kmdb_ctrl.sv =====
// ============================================================================
// kmdb_ctrl
// sequencer for one search: check, clear, seed, dequeue and expand squares
// ============================================================================
`default_nettype none

module kmdb_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire kmdb_pkg::t_status i_status,
    output kmdb_pkg::t_cmd         o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_CLEAR  = 9'b000000100,
        S_SEED   = 9'b000001000,
        S_FETCH  = 9'b000010000,
        S_LOAD   = 9'b000100000,
        S_MOVE   = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.off_board) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FINISH;
                end else if (i_status.same_square) begin
                    o_cmd.res_zero  = 1'b1;
                    o_cmd.res_reach = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.clr_start = 1'b1;
                    n_state         = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                if (i_status.fifo_empty) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.issue = 1'b1;
                o_cmd.test  = 1'b1;
                if (i_status.hit) begin
                    n_state = S_FINISH;
                end else if (i_status.move_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.test = 1'b1;
                if (i_status.hit) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/kmdb_dp.sv =====
// ============================================================================
// kmdb_dp
// search datapath: visited store, square queue, move generator, result regs
// ============================================================================
`default_nettype none

module kmdb_dp #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [kmdb_pkg::SIDE_W-1:0]   i_cfg_data,
    input  wire kmdb_pkg::t_in                 i_in_data,
    input  wire kmdb_pkg::t_cmd                i_cmd,
    output kmdb_pkg::t_status                  o_status,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output kmdb_pkg::t_out                     o_out_data
);

    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int ADDR_W  = 2 * COORD_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int PTR_W   = ADDR_W + 1;
    localparam int NB_W    = COORD_W + 2;
    localparam int SIDE_W  = kmdb_pkg::SIDE_W;
    localparam int DIST_W  = kmdb_pkg::DIST_W;
    localparam int CIN_W   = kmdb_pkg::COORD_IN_W;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIST_W-1:0]  steps;
    } t_fifo_entry;

    logic        vis_mem  [DEPTH];
    t_fifo_entry fifo_mem [DEPTH];

    logic [SIDE_W-1:0]         r_side;
    kmdb_pkg::t_in             r_query;
    logic [COORD_W-1:0]        r_cur_row;
    logic [COORD_W-1:0]        r_cur_col;
    logic [DIST_W-1:0]         r_cur_dist;
    logic [kmdb_pkg::MOVE_W-1:0] r_move;
    logic [ADDR_W-1:0]         r_clr;
    logic [PTR_W-1:0]          r_head;
    logic [PTR_W-1:0]          r_tail;
    logic                      r_p_valid;
    logic [COORD_W-1:0]        r_p_row;
    logic [COORD_W-1:0]        r_p_col;
    logic                      r_vis_rd;
    t_fifo_entry               r_fifo_rd;
    kmdb_pkg::t_out            r_res;
    logic                      r_out_valid;
    kmdb_pkg::t_out            r_out;

    logic [SIDE_W-1:0]        eff_side;
    logic signed [NB_W-1:0]   nb_row;
    logic signed [NB_W-1:0]   nb_col;
    logic                     in_board;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        start_addr;
    logic [DIST_W-1:0]        next_dist;
    logic                     fresh;
    logic                     hit;
    logic                     push;
    logic                     vis_we;
    logic [ADDR_W-1:0]        vis_waddr;
    logic                     vis_wdata;
    logic                     fifo_we;
    logic [ADDR_W-1:0]        fifo_waddr;
    t_fifo_entry              fifo_wdata;

    assign eff_side = (r_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : r_side;

    // neighbor of the current square for the move being issued
    assign nb_row = $signed({2'b00, r_cur_row})
                  + NB_W'(kmdb_pkg::KNIGHT_ROW[r_move]);
    assign nb_col = $signed({2'b00, r_cur_col})
                  + NB_W'(kmdb_pkg::KNIGHT_COL[r_move]);
    assign in_board = !nb_row[NB_W-1] && !nb_col[NB_W-1]
                   && (SIDE_W'(nb_row[NB_W-2:0]) < eff_side)
                   && (SIDE_W'(nb_col[NB_W-2:0]) < eff_side);
    assign rd_addr    = {nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]};
    assign start_addr = {r_query.start_row[COORD_W-1:0], r_query.start_col[COORD_W-1:0]};

    assign next_dist = (r_cur_dist == '1) ? r_cur_dist : r_cur_dist + DIST_W'(1);

    // the staged neighbor is new when its visited bit reads clear
    assign fresh = r_p_valid && !r_vis_rd;
    assign hit   = fresh && (CIN_W'(r_p_row) == r_query.target_row)
                         && (CIN_W'(r_p_col) == r_query.target_col);
    assign push  = i_cmd.test && fresh;

    always_comb begin
        vis_we    = 1'b0;
        vis_waddr = r_clr;
        vis_wdata = 1'b0;
        if (i_cmd.clear) begin
            vis_we = 1'b1;
        end else if (i_cmd.seed) begin
            vis_we    = 1'b1;
            vis_waddr = start_addr;
            vis_wdata = 1'b1;
        end else if (push) begin
            vis_we    = 1'b1;
            vis_waddr = {r_p_row, r_p_col};
            vis_wdata = 1'b1;
        end
    end

    always_comb begin
        fifo_we    = 1'b0;
        fifo_waddr = r_tail[ADDR_W-1:0];
        fifo_wdata = '{row: r_p_row, col: r_p_col, steps: next_dist};
        if (i_cmd.seed) begin
            fifo_we    = 1'b1;
            fifo_waddr = '0;
            fifo_wdata = '{row: r_query.start_row[COORD_W-1:0],
                           col: r_query.start_col[COORD_W-1:0],
                           steps: DIST_W'(1)};
        end else if (push && !r_tail[ADDR_W]) begin
            fifo_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        r_vis_rd <= vis_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (i_cmd.fetch) begin
            r_fifo_rd <= fifo_mem[r_head[ADDR_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= kmdb_pkg::SIDE_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_side <= i_cfg_data;
            end
            if (i_cmd.seed) begin
                r_head <= '0;
                r_tail <= PTR_W'(1);
            end else begin
                if (i_cmd.fetch) begin
                    r_head <= r_head + PTR_W'(1);
                end
                if (push && !r_tail[ADDR_W]) begin
                    r_tail <= r_tail + PTR_W'(1);
                end
            end
            r_p_valid <= i_cmd.issue && in_board;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_query <= i_in_data;
        end
        if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + ADDR_W'(1);
        end
        if (i_cmd.load) begin
            r_cur_row  <= r_fifo_rd.row;
            r_cur_col  <= r_fifo_rd.col;
            r_cur_dist <= r_fifo_rd.steps;
            r_move     <= '0;
        end else if (i_cmd.issue) begin
            r_move <= r_move + kmdb_pkg::MOVE_W'(1);
        end
        r_p_row <= nb_row[COORD_W-1:0];
        r_p_col <= nb_col[COORD_W-1:0];
        if (i_cmd.res_zero) begin
            r_res <= '{move_count: '0, reachable: i_cmd.res_reach};
        end else if (push && hit) begin
            r_res <= '{move_count: next_dist - DIST_W'(1), reachable: 1'b1};
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        o_status.off_board = ({1'b0, r_query.start_row}  >= eff_side)
                          || ({1'b0, r_query.start_col}  >= eff_side)
                          || ({1'b0, r_query.target_row} >= eff_side)
                          || ({1'b0, r_query.target_col} >= eff_side);
        o_status.same_square = (r_query.start_row == r_query.target_row)
                            && (r_query.start_col == r_query.target_col);
        o_status.clear_last  = (r_clr == {ADDR_W{1'b1}});
        o_status.fifo_empty  = (r_head == r_tail);
        o_status.move_last   = (r_move == kmdb_pkg::MOVE_W'(kmdb_pkg::MOVES - 1));
        o_status.hit         = hit;
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/knight_move_distance_bfs.sv =====
// ============================================================================
// knight_move_distance_bfs
// least knight moves between two squares by breadth-first search
// ============================================================================
// early exit: off-board or start equal to target goes from check straight to finish
// search: clear sweep over D = 2^(2*clog2(MAX_SIDE)) visited bits (65536 at MAX_SIDE 256),
// seed, then fetch, load, eight moves with one store read each and drain per dequeued square
// throughput: one request at a time; next request taken as soon as the result is registered
// reset: synchronous active low; board side returns to 8, control state clears
`default_nettype none

module knight_move_distance_bfs #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire kmdb_pkg::t_in               i_in_data,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output kmdb_pkg::t_out                   o_out_data,
    // board side register
    input  wire logic                        i_cfg_we,
    input  wire logic [kmdb_pkg::SIDE_W-1:0] i_cfg_data
);

    // the controller walks: check -> clear visited bits -> seed start square ->
    // repeatedly dequeue a square and try its eight moves -> finish.
    // the datapath holds a one-bit visited store and a queue of squares that
    // carries each square's distance, so no second store read is needed.
    kmdb_pkg::t_cmd    cmd;
    kmdb_pkg::t_status status;

    kmdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // moves are pipelined one per cycle: store read issued for move k while
    // move k-1 is tested; neighbors of one square never alias, so no hazard
    kmdb_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // an accepted request keeps the block busy in the following cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but block not busy afterwards");

    // a result appears only after the controller emits one
    a_out_from_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.emit))
        else $error("result valid without emit");

    // emit never overwrites a result that is still stalled
    a_emit_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("emit while result register held");

    // clearing and expanding never overlap
    a_clear_alone : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (!cmd.issue && !cmd.test && !cmd.seed))
        else $error("clear sweep overlaps search");

endmodule

`default_nettype wire
